@@ src/bas_pkg.sv @@
// Shared types, constants and the step table for the accelerating speed adjust unit.
// No dependencies; used by every module in src.
`default_nettype none

package bas_pkg;

  localparam int TIME_BITS  = 32;
  localparam int SPEED_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int STEP_BITS  = 7;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET     = 16'd1;
  localparam logic [CFG_BITS-1:0]   INTERVAL_RESET  = 16'd500;
  localparam logic [CFG_BITS-1:0]   MAX_SPEED_RESET = 16'd65535;

  typedef enum logic [1:0] {
    REG_REPEAT_INTERVAL = 2'd0,
    REG_MAX_SPEED       = 2'd1,
    REG_START_SPEED     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FAST = 2'd1,
    MODE_SLOW = 2'd2
  } mode_t;

  typedef struct packed {
    logic        fast_pressed;
    logic        slow_pressed;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [1:0]  button_mode;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] repeat_interval_ms;
    logic [CFG_BITS-1:0] max_speed;
  } cfg_t;

  localparam logic [STEP_BITS-1:0] STEP_TABLE [8] = '{
    7'd1, 7'd1, 7'd2, 7'd5, 7'd10, 7'd20, 7'd50, 7'd100
  };

  localparam logic [2:0] STEP_LAST = 3'd7;
  localparam logic [2:0] STEP_PRESS = 3'd1;

endpackage

`default_nettype wire

@@ src/bas_cfg.sv @@
// Configuration register file for the speed adjust unit.
// Depends on bas_pkg.
`default_nettype none

module bas_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [bas_pkg::CFG_BITS-1:0] cfg_data,
  output bas_pkg::cfg_t                    cfg
);

  logic [bas_pkg::CFG_BITS-1:0] repeat_interval_ms;
  logic [bas_pkg::CFG_BITS-1:0] max_speed;

  // start speed is taken only at reset, where it is itself reset; a write is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval_ms <= bas_pkg::INTERVAL_RESET;
      max_speed          <= bas_pkg::MAX_SPEED_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bas_pkg::REG_REPEAT_INTERVAL) begin
        repeat_interval_ms <= cfg_data;
      end
      if (cfg_index == bas_pkg::REG_MAX_SPEED) begin
        max_speed <= cfg_data;
      end
    end
  end

  assign cfg.repeat_interval_ms = repeat_interval_ms;
  assign cfg.max_speed          = max_speed;

endmodule

`default_nettype wire

@@ src/bas_core.sv @@
// Button state machine, step index and saturating speed register.
// Depends on bas_pkg; driven one item per advance by the top level.
`default_nettype none

module bas_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  bas_pkg::in_item_t  item,
  input  bas_pkg::cfg_t      cfg,
  output bas_pkg::out_item_t result
);

  bas_pkg::mode_t                    state, state_next;
  logic [bas_pkg::TIME_BITS-1:0]     last_change_ms, last_change_ms_next;
  logic [2:0]                        step_index, step_index_next;
  logic [bas_pkg::SPEED_BITS-1:0]    speed_value, speed_value_next;

  logic [bas_pkg::TIME_BITS-1:0]     now_t;
  logic [bas_pkg::TIME_BITS-1:0]     elapsed;
  logic                              repeat_due;
  logic                              move_en;
  logic                              move_down;
  logic [bas_pkg::STEP_BITS-1:0]     amount;
  logic [bas_pkg::SPEED_BITS-1:0]    limit;
  logic signed [bas_pkg::SPEED_BITS+1:0] sum;
  logic [bas_pkg::SPEED_BITS-1:0]    moved;

  assign now_t      = bas_pkg::TIME_BITS'(item.now_ms);
  assign elapsed    = now_t - last_change_ms;
  assign repeat_due = elapsed > bas_pkg::TIME_BITS'(cfg.repeat_interval_ms);
  assign limit      = (cfg.max_speed == '0) ? bas_pkg::SPEED_BITS'(1) : cfg.max_speed;

  // saturating add or subtract, clamp to 1..limit
  always_comb begin
    sum = move_down
        ? $signed({2'b00, speed_value}) - $signed({11'd0, amount})
        : $signed({2'b00, speed_value}) + $signed({11'd0, amount});
    if (sum < 18'sd1) begin
      moved = bas_pkg::SPEED_BITS'(1);
    end else if (sum > $signed({2'b00, limit})) begin
      moved = limit;
    end else begin
      moved = sum[bas_pkg::SPEED_BITS-1:0];
    end
  end

  always_comb begin
    state_next          = state;
    last_change_ms_next = last_change_ms;
    step_index_next     = step_index;
    move_en             = 1'b0;
    move_down           = 1'b0;
    amount              = bas_pkg::STEP_TABLE[step_index];
    unique case (state)
      bas_pkg::MODE_IDLE: begin
        if (item.fast_pressed || item.slow_pressed) begin
          last_change_ms_next = now_t;
          step_index_next     = '0;
          move_en             = 1'b1;
          move_down           = !item.fast_pressed;
          amount              = bas_pkg::STEP_TABLE[bas_pkg::STEP_PRESS];
          state_next          = item.fast_pressed ? bas_pkg::MODE_FAST : bas_pkg::MODE_SLOW;
        end
      end
      bas_pkg::MODE_FAST, bas_pkg::MODE_SLOW: begin
        move_down = (state == bas_pkg::MODE_SLOW);
        if (!(move_down ? item.slow_pressed : item.fast_pressed)) begin
          state_next = bas_pkg::MODE_IDLE;
        end
        // the release poll still gets its repeat check
        if (repeat_due) begin
          move_en             = 1'b1;
          last_change_ms_next = now_t;
          if (step_index != bas_pkg::STEP_LAST) begin
            step_index_next = step_index + 3'd1;
          end
        end
      end
      default: begin
        state_next = bas_pkg::MODE_IDLE;
      end
    endcase
    speed_value_next = move_en ? moved : speed_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bas_pkg::MODE_IDLE;
      last_change_ms <= '0;
      step_index     <= '0;
      speed_value    <= bas_pkg::SPEED_RESET;
    end else if (advance) begin
      state          <= state_next;
      last_change_ms <= last_change_ms_next;
      step_index     <= step_index_next;
      speed_value    <= speed_value_next;
    end
  end

  assign result.speed       = speed_value_next;
  assign result.button_mode = 2'(state_next);

`ifndef SYNTH
  a_speed_nonzero: assert property (@(posedge clk) disable iff (rst)
    speed_value != '0)
    else $error("speed register reached zero");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(speed_value) && $stable(step_index) && $stable(state))
    else $error("state changed without an item");

  a_step_monotonic: assert property (@(posedge clk) disable iff (rst)
    advance && state != bas_pkg::MODE_IDLE |=>
      step_index == $past(step_index) || step_index == $past(step_index) + 3'd1)
    else $error("step index jumped while held");
`endif

endmodule

`default_nettype wire

@@ src/button_accelerating_speed_adjust_unit.sv @@
// Top level of the accelerating button speed adjust unit: input register, core, result register.
// Depends on bas_pkg, bas_cfg and bas_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_ready   | in_item  (fast_pressed, slow_pressed, now_ms)
//   out      | out_valid / out_ready | out_item (speed, button_mode)
//   cfg      | cfg_we                | cfg_index, cfg_data (16 bits, no read-back)
//
// A result is registered: the item sits in the input register while the state update
// runs, and the result register loads when the item advances. One item per clock is
// sustained while the output is not stalled; the state update is a single add/clamp and
// a 32-bit compare. Reset clears the machine to idle with speed 1 and the valid flags and
// config registers to their defaults; the payload registers are not reset.
// A stalled output holds the result register and then the input register; the input
// side keeps accepting while either stage has room.
`default_nettype none

module button_accelerating_speed_adjust_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  bas_pkg::in_item_t                 in_item,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output bas_pkg::out_item_t                out_item,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [bas_pkg::CFG_BITS-1:0] cfg_data
);

  bas_pkg::cfg_t      cfg;
  bas_pkg::in_item_t  in_q;
  logic               in_valid_q;
  logic               advance;
  bas_pkg::out_item_t result;

  bas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held item into the result register when that register is free
  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  // payload needs no reset; load only on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  bas_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef SYNTH
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held item lost while stalled");

  a_ready_means_room: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_valid_q && out_valid && !out_ready)
    else $error("input stalled with room downstream");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result not shown after advance");
`endif

endmodule

`default_nettype wire
